// ===== design/pbpm_pkg.sv =====
package pbpm_pkg;

    localparam int unsigned MaxEntriesDefault = 32;
    localparam int unsigned NumQueuesDefault  = 8;

    localparam int unsigned ModeW   = 4;
    localparam int unsigned EntryW  = 5;
    localparam int unsigned QueueW  = 3;
    localparam int unsigned ParentW = 5;

    localparam logic [ModeW-1:0] MODE_ALLOC   = 4'd0;
    localparam logic [ModeW-1:0] MODE_FREE    = 4'd1;
    localparam logic [ModeW-1:0] MODE_ENQ     = 4'd2;
    localparam logic [ModeW-1:0] MODE_DEQ     = 4'd3;
    localparam logic [ModeW-1:0] MODE_REMOVE  = 4'd4;
    localparam logic [ModeW-1:0] MODE_PEEK    = 4'd5;
    localparam logic [ModeW-1:0] MODE_ADD_CH  = 4'd6;
    localparam logic [ModeW-1:0] MODE_POP_CH  = 4'd7;
    localparam logic [ModeW-1:0] MODE_UNL_CH  = 4'd8;

    typedef struct packed {
        logic [ModeW-1:0]   mode;
        logic [EntryW-1:0]  entry;
        logic [QueueW-1:0]  queue;
        logic [ParentW-1:0] parent;
    } t_req;

    typedef struct packed {
        logic [EntryW-1:0] result_entry;
        logic              result_valid;
        logic              queue_empty;
        logic              parent_childless;
    } t_rsp;

endpackage

// ===== design/pbpm_if.sv =====
interface pbpm_req_if;
    import pbpm_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pbpm_rsp_if;
    import pbpm_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/process_block_pool_manager.sv =====
// Channel   | Direction | Handshake     | Payload
// i_req     | in        | valid/ready   | mode, entry, queue, parent
// o_rsp     | out       | valid/ready   | result_entry, result_valid, queue_empty,
//           |           |               | parent_childless
// A response is offered once the sequencer has run the steps of its mode, since the
// one read port of the link memory serves one sequencer step at a time; a removal walk
// passes S_RM_WK, S_RD and S_RM_W for each queue link it visits, up to MAX_ENTRIES links.
// Reset is synchronous and active low; per-entry valid bits give the null links and
// the descending free list without a sweep.
// A stalled sink blocks new requests; ready returns in the cycle after it takes the response.
module process_block_pool_manager #(
    parameter int unsigned MAX_ENTRIES = pbpm_pkg::MaxEntriesDefault,
    parameter int unsigned NUM_QUEUES  = pbpm_pkg::NumQueuesDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbpm_req_if.sink   i_req,
    pbpm_rsp_if.source o_rsp
);
    import pbpm_pkg::*;

    // Links are wide enough to hold MAX_ENTRIES (one bit wider than an index when MAX_ENTRIES
    // is a power of two) so that the value MAX_ENTRIES encodes null, as does anything above it.
    localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned LW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);
    localparam int unsigned SW = $clog2(MAX_ENTRIES + 1);

    // Field selects of one link word.
    localparam int unsigned F_NEXT = 0;
    localparam int unsigned F_PREV = 1;
    localparam int unsigned F_PAR  = 2;
    localparam int unsigned F_FC   = 3;
    localparam int unsigned F_SN   = 4;
    localparam int unsigned F_SP   = 5;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_RD     = 5'd2;
    localparam logic [4:0] S_ALLOC  = 5'd3;
    localparam logic [4:0] S_ENQ_T  = 5'd4;
    localparam logic [4:0] S_ENQ_W  = 5'd5;
    localparam logic [4:0] S_HEAD   = 5'd6;
    localparam logic [4:0] S_RM_T   = 5'd7;
    localparam logic [4:0] S_RM_WK  = 5'd8;
    localparam logic [4:0] S_RM_E   = 5'd9;
    localparam logic [4:0] S_RM_W   = 5'd10;
    localparam logic [4:0] S_ADD_P  = 5'd11;
    localparam logic [4:0] S_ADD_W  = 5'd12;
    localparam logic [4:0] S_UNL_E  = 5'd13;
    localparam logic [4:0] S_UNL_P  = 5'd14;
    localparam logic [4:0] S_UNL_W  = 5'd15;
    localparam logic [4:0] S_FLAGS  = 5'd16;
    localparam logic [4:0] S_FLAGR  = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    // Link memory: six link fields per entry. A register-array with a
    // per-field write enable; the block reads at most one entry per cycle.
    // Per-entry valid bits give the reset value without a sweep.
    typedef logic [6*LW-1:0] t_word;
    t_word            r_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_vld;
    logic [LW-1:0]    r_tail [NUM_QUEUES];

    logic [4:0]       r_st, n_st;
    t_req             r_req;
    t_rsp             r_rsp;
    logic             r_out_v;
    logic [LW-1:0]    r_free_top;

    // Scratch registers of the sequencer.
    logic [LW-1:0]    r_a, r_b, r_c, r_d;    // general link holders
    logic [SW-1:0]    r_steps;
    logic             r_found;
    logic             r_qe;
    logic [4:0]       r_ret;                 // state to take after a read

    // One read port: address register, registered data.
    logic [IW-1:0]    r_raddr;
    t_word            r_rdata;
    logic             r_rvld;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;

    // Up to three field writes per cycle into different or same entries.
    logic             we0, we1, we2;
    logic [IW-1:0]    wa0, wa1, wa2;
    logic [5:0]       wm0, wm1, wm2;
    t_word            wd0, wd1, wd2;

    function automatic logic okl(input logic [LW-1:0] x);
        return x < NIL;
    endfunction

    function automatic logic [LW-1:0] fld(input t_word w, input int unsigned f);
        return w[f*LW +: LW];
    endfunction

    function automatic t_word put(input logic [LW-1:0] v, input int unsigned f);
        t_word w;
        w = '0;
        w[f*LW +: LW] = v;
        return w;
    endfunction

    // Read data with the reset value for never-touched entries.
    t_word rdw;
    always_comb begin
        if (r_rvld) begin
            rdw = r_rdata;
        end else begin
            rdw = {6{NIL}};
            if (r_raddr != '0) begin
                rdw[F_NEXT*LW +: LW] = LW'(r_raddr) - LW'(1);
            end
        end
    end

    logic          e_ok, p_ok, q_ok;
    logic [LW-1:0] e_l, p_l, qt;
    logic [IW-1:0] e_i, p_i;
    logic [QW-1:0] q_i;
    always_comb begin
        e_ok = 32'(r_req.entry) < MAX_ENTRIES;
        p_ok = 32'(r_req.parent) < MAX_ENTRIES;
        q_ok = 32'(r_req.queue) < NUM_QUEUES;
        e_l  = LW'(r_req.entry);
        p_l  = LW'(r_req.parent);
        e_i  = IW'(r_req.entry);
        p_i  = IW'(r_req.parent);
        q_i  = QW'(r_req.queue);
        qt   = q_ok ? r_tail[q_i] : NIL;
    end

    assign i_req.ready = (r_st == S_IDLE) && !r_out_v;
    assign o_rsp.valid = r_out_v;
    assign o_rsp.data  = r_rsp;

    logic             n_tail_we;
    logic [LW-1:0]    n_tail_v;
    logic [LW-1:0]    n_free_top;
    logic [LW-1:0]    n_a, n_b, n_c, n_d;
    logic [SW-1:0]    n_steps;
    logic             n_found, n_qe, n_out_v;
    logic [4:0]       n_ret;
    t_rsp             n_rsp;

    always_comb begin
        n_st = r_st; n_ret = r_ret;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d;
        n_steps = r_steps; n_found = r_found; n_qe = r_qe;
        n_free_top = r_free_top; n_rsp = r_rsp; n_out_v = r_out_v;
        n_tail_we = 1'b0; n_tail_v = NIL;
        rd_en = 1'b0; rd_addr = '0;
        we0 = 1'b0; wa0 = '0; wm0 = '0; wd0 = '0;
        we1 = 1'b0; wa1 = '0; wm1 = '0; wd1 = '0;
        we2 = 1'b0; wa2 = '0; wm2 = '0; wd2 = '0;
        if (r_out_v && o_rsp.ready) n_out_v = 1'b0;

        unique case (r_st)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_st = S_DISP;
                    n_rsp = '0;
                end
            end
            S_DISP: begin
                n_found = 1'b0;
                unique case (r_req.mode)
                    MODE_ALLOC: begin
                        if (okl(r_free_top)) begin
                            rd_en = 1'b1; rd_addr = IW'(r_free_top);
                            n_st = S_RD; n_ret = S_ALLOC;
                        end else n_st = S_FLAGS;
                    end
                    MODE_FREE: begin
                        if (e_ok) begin
                            we0 = 1'b1; wa0 = e_i; wm0 = 6'b000001;
                            wd0 = put(r_free_top, F_NEXT);
                            n_free_top = e_l; n_found = 1'b1;
                        end
                        n_st = S_FLAGS;
                    end
                    MODE_ENQ: begin
                        if (e_ok && q_ok) begin
                            n_found = 1'b1;
                            if (!okl(qt)) begin
                                we0 = 1'b1; wa0 = e_i; wm0 = 6'b000011;
                                wd0 = put(e_l, F_NEXT) | put(e_l, F_PREV);
                                n_tail_we = 1'b1; n_tail_v = e_l;
                                n_st = S_FLAGS;
                            end else begin
                                rd_en = 1'b1; rd_addr = IW'(qt);
                                n_st = S_RD; n_ret = S_ENQ_T;
                            end
                        end else n_st = S_FLAGS;
                    end
                    MODE_DEQ, MODE_PEEK: begin
                        if (q_ok && okl(qt)) begin
                            rd_en = 1'b1; rd_addr = IW'(qt);
                            n_st = S_RD; n_ret = S_HEAD;
                        end else n_st = S_FLAGS;
                    end
                    MODE_REMOVE: begin
                        if (e_ok && q_ok && okl(qt)) begin
                            n_b = e_l;
                            rd_en = 1'b1; rd_addr = IW'(qt);
                            n_st = S_RD; n_ret = S_RM_T;
                        end else n_st = S_FLAGS;
                    end
                    MODE_ADD_CH: begin
                        if (e_ok && p_ok) begin
                            rd_en = 1'b1; rd_addr = p_i;
                            n_st = S_RD; n_ret = S_ADD_P;
                        end else n_st = S_FLAGS;
                    end
                    MODE_POP_CH: begin
                        if (p_ok) begin
                            rd_en = 1'b1; rd_addr = p_i;
                            n_st = S_RD; n_ret = S_UNL_E;
                            n_d = 1'b0 ? NIL : NIL;
                            n_c = NIL;  // marks "first child still to fetch"
                        end else n_st = S_FLAGS;
                    end
                    MODE_UNL_CH: begin
                        if (e_ok) begin
                            n_b = e_l;
                            rd_en = 1'b1; rd_addr = e_i;
                            n_st = S_RD; n_ret = S_UNL_P;
                        end else n_st = S_FLAGS;
                    end
                    default: n_st = S_FLAGS;
                endcase
            end
            S_RD: n_st = r_ret;
            S_ALLOC: begin
                n_free_top = fld(rdw, F_NEXT);
                we0 = 1'b1; wa0 = IW'(r_free_top); wm0 = 6'b111111;
                wd0 = {6{NIL}};
                n_rsp.result_entry = EntryW'(r_free_top); n_found = 1'b1;
                n_st = S_FLAGS;
            end
            S_ENQ_T: begin
                // rdw is the tail; head = next of tail.
                n_a = fld(rdw, F_NEXT);
                we0 = 1'b1; wa0 = e_i; wm0 = 6'b000011;
                wd0 = put(fld(rdw, F_NEXT), F_NEXT) | put(qt, F_PREV);
                we1 = 1'b1; wa1 = IW'(qt); wm1 = 6'b000001;
                wd1 = put(e_l, F_NEXT);
                n_st = S_ENQ_W;
            end
            S_ENQ_W: begin
                if (okl(r_a)) begin
                    we0 = 1'b1; wa0 = IW'(r_a); wm0 = 6'b000010;
                    wd0 = put(e_l, F_PREV);
                end
                n_tail_we = 1'b1; n_tail_v = e_l;
                n_st = S_FLAGS;
            end
            S_HEAD: begin
                if (okl(fld(rdw, F_NEXT))) begin
                    if (r_req.mode == MODE_PEEK) begin
                        n_rsp.result_entry = EntryW'(fld(rdw, F_NEXT));
                        n_found = 1'b1;
                        n_st = S_FLAGS;
                    end else begin
                        n_b = fld(rdw, F_NEXT);
                        rd_en = 1'b1; rd_addr = IW'(qt);
                        n_st = S_RD; n_ret = S_RM_T;
                    end
                end else n_st = S_FLAGS;
            end
            S_RM_T: begin
                // rdw is the tail; r_b is the target.
                if (fld(rdw, F_NEXT) == qt) begin
                    if (qt == r_b) begin
                        rd_en = 1'b1; rd_addr = IW'(r_b);
                        n_st = S_RD; n_ret = S_RM_E;
                    end else n_st = S_FLAGS;
                end else if (r_b == qt) begin
                    rd_en = 1'b1; rd_addr = IW'(r_b);
                    n_st = S_RD; n_ret = S_RM_E;
                end else begin
                    n_a = fld(rdw, F_NEXT); n_steps = '0;
                    n_st = S_RM_WK;
                end
            end
            S_RM_WK: begin
                // One link per pass: test r_a, else read its next link.
                if (okl(r_a) && r_a != qt && r_a != r_b
                        && 32'(r_steps) < MAX_ENTRIES) begin
                    rd_en = 1'b1; rd_addr = IW'(r_a);
                    n_st = S_RD; n_ret = S_RM_W;
                end else if (r_a == r_b) begin
                    rd_en = 1'b1; rd_addr = IW'(r_b);
                    n_st = S_RD; n_ret = S_RM_E;
                end else n_st = S_FLAGS;
            end
            S_RM_W: begin
                n_a = fld(rdw, F_NEXT);
                n_steps = r_steps + SW'(1);
                n_st = S_RM_WK;
            end
            S_RM_E: begin
                // rdw is the removed entry r_b. Its own links are cleared in the same cycle as
                // the neighbors are joined, with that clear merged last.
                if (fld(rdw, F_NEXT) == r_b && qt == r_b) begin
                    n_tail_we = 1'b1; n_tail_v = NIL;
                end else begin
                    if (okl(fld(rdw, F_PREV))) begin
                        we1 = 1'b1; wa1 = IW'(fld(rdw, F_PREV)); wm1 = 6'b000001;
                        wd1 = put(fld(rdw, F_NEXT), F_NEXT);
                    end
                    if (okl(fld(rdw, F_NEXT))) begin
                        we0 = 1'b1; wa0 = IW'(fld(rdw, F_NEXT)); wm0 = 6'b000010;
                        wd0 = put(fld(rdw, F_PREV), F_PREV);
                    end
                    if (r_b == qt) begin
                        n_tail_we = 1'b1; n_tail_v = fld(rdw, F_PREV);
                    end
                end
                we2 = 1'b1; wa2 = IW'(r_b); wm2 = 6'b000011; wd2 = {6{NIL}};
                n_rsp.result_entry = EntryW'(r_b); n_found = 1'b1;
                n_st = S_FLAGS;
            end
            S_ADD_P: begin
                n_a = fld(rdw, F_FC);
                we0 = 1'b1; wa0 = e_i; wm0 = 6'b110100;
                wd0 = put(p_l, F_PAR) | put(okl(fld(rdw, F_FC)) ? fld(rdw, F_FC) : NIL, F_SN)
                    | put(NIL, F_SP);
                we1 = 1'b1; wa1 = p_i; wm1 = 6'b001000;
                wd1 = put(e_l, F_FC);
                n_st = S_ADD_W;
            end
            S_ADD_W: begin
                // The new child has no left sibling, even when it was the old first child.
                if (okl(r_a) && r_a != e_l) begin
                    we0 = 1'b1; wa0 = IW'(r_a); wm0 = 6'b100000;
                    wd0 = put(e_l, F_SP);
                end
                n_found = 1'b1;
                n_st = S_FLAGS;
            end
            S_UNL_E: begin
                // Pop: rdw is the parent; fetch its first child.
                if (okl(fld(rdw, F_FC))) begin
                    n_b = fld(rdw, F_FC);
                    rd_en = 1'b1; rd_addr = IW'(fld(rdw, F_FC));
                    n_st = S_RD; n_ret = S_UNL_P;
                end else n_st = S_FLAGS;
            end
            S_UNL_P: begin
                // rdw is the child r_b; keep its links, read the parent.
                n_c = fld(rdw, F_SN); n_d = fld(rdw, F_SP); n_a = fld(rdw, F_PAR);
                if (okl(fld(rdw, F_PAR))) begin
                    rd_en = 1'b1; rd_addr = IW'(fld(rdw, F_PAR));
                    n_st = S_RD; n_ret = S_UNL_W;
                end else n_st = S_FLAGS;
            end
            S_UNL_W: begin
                // The parent's first-child update and the left sibling may hit
                // the same entry only when the parent is also the sibling,
                // which the field masks keep apart.
                if (fld(rdw, F_FC) == r_b) begin
                    we0 = 1'b1; wa0 = IW'(r_a); wm0 = 6'b001000;
                    wd0 = put(r_c, F_FC);
                end
                if (okl(r_d)) begin
                    we1 = 1'b1; wa1 = IW'(r_d); wm1 = 6'b010000;
                    wd1 = put(r_c, F_SN);
                end
                if (okl(r_c)) begin
                    we2 = 1'b1; wa2 = IW'(r_c); wm2 = 6'b100000;
                    wd2 = put(r_d, F_SP);
                end
                n_rsp.result_entry = EntryW'(r_b); n_found = 1'b1;
                n_st = S_FLAGS;
            end
            S_FLAGS: begin
                n_qe = !q_ok || !okl(qt);
                rd_en = 1'b1; rd_addr = p_i;
                n_st = S_RD; n_ret = S_FLAGR;
            end
            S_FLAGR: begin
                n_rsp.result_valid     = r_found;
                if (!r_found) n_rsp.result_entry = '0;
                n_rsp.queue_empty      = r_qe;
                n_rsp.parent_childless = !p_ok || !okl(fld(rdw, F_FC));
                n_st = S_OUT;
            end
            S_OUT: begin
                n_out_v = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    // Unlink of an entry still needing its own links cleared.
    logic clr_child;
    assign clr_child = (r_st == S_UNL_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_out_v <= 1'b0;
            r_free_top <= LW'(MAX_ENTRIES - 1);
            r_vld <= '0;
            r_rvld <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++) r_tail[q] <= NIL;
        end else begin
            r_st <= n_st;
            r_out_v <= n_out_v;
            r_free_top <= n_free_top;
            if (n_tail_we) r_tail[q_i] <= n_tail_v;
            if (rd_en) r_rvld <= r_vld[rd_addr];
            if (we0) r_vld[wa0] <= 1'b1;
            if (we1) r_vld[wa1] <= 1'b1;
            if (we2) r_vld[wa2] <= 1'b1;
            if (clr_child) r_vld[IW'(r_b)] <= 1'b1;
        end
    end

    // Memory writes merge the old word (or its reset value) under the masks.
    function automatic t_word rst_word(input int unsigned i);
        t_word w;
        w = {6{NIL}};
        if (i != 0) w[F_NEXT*LW +: LW] = LW'(i - 1);
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            t_word cur;
            cur = r_vld[i] ? r_mem[i] : rst_word(i);
            for (int f = 0; f < 6; f++) begin
                if (we0 && wa0 == IW'(i) && wm0[f]) cur[f*LW +: LW] = wd0[f*LW +: LW];
                if (we1 && wa1 == IW'(i) && wm1[f]) cur[f*LW +: LW] = wd1[f*LW +: LW];
                if (we2 && wa2 == IW'(i) && wm2[f]) cur[f*LW +: LW] = wd2[f*LW +: LW];
            end
            if (clr_child && r_b == LW'(i)) begin
                cur[F_PAR*LW +: LW] = NIL;
                cur[F_SN*LW +: LW]  = NIL;
                cur[F_SP*LW +: LW]  = NIL;
            end
            r_mem[i] <= cur;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_raddr <= rd_addr;
        end
        if (i_req.valid && i_req.ready) r_req <= i_req.data;
        r_ret <= n_ret;
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d;
        r_steps <= n_steps; r_found <= n_found; r_qe <= n_qe;
        r_rsp <= n_rsp;
    end

`ifndef ASSERT_OFF
    // A response is never raised while the sequencer is busy.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_st == S_IDLE)
        else $error("response pending while busy");
    // An invalid result carries a zero entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_rsp.result_valid) |-> r_rsp.result_entry == '0)
        else $error("invalid result with nonzero entry");
    // The removal walk never exceeds the pool size.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_RM_W |-> 32'(r_steps) < MAX_ENTRIES)
        else $error("walk overran");
`endif

endmodule
